### sv/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared types and constants of the degenerate triangle filter.
// ----------------------------------------------------------------------------
package dtf_pkg;

    localparam int IDX_W      = 16;
    localparam int SLOT_W     = 12;
    localparam int POS_W      = 16;
    localparam int POS_EXT_W  = 32;
    localparam int LIM_W      = 17;
    localparam int COUNT_W    = 13;
    localparam int THR_W      = 63;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic
    {
        OP_LOAD     = 1'b0,
        OP_TRIANGLE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_KEPT       = 2'd0,
        STATUS_BAD_INDEX  = 2'd1,
        STATUS_DEGENERATE = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_THRESHOLD = 1'b1;

    typedef struct packed
    {
        logic             bad;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } tri_tag_t;

endpackage

### sv/degenerate_triangle_filter.sv
// ----------------------------------------------------------------------------
// degenerate_triangle_filter
// Vertex store with a triangle test: bad corner index or tiny cross product.
// ----------------------------------------------------------------------------
// A triangle word passes the store read, edge vector, cross term, magnitude,
//   partial product, square and output registers before done rises.
// Throughput: one word per cycle, loads and triangles alike; busy stays low.
// The result side is a plain strobe; nothing holds the pipeline.
// Reset clears the valid pipe and both registers; the store is undefined.
// ----------------------------------------------------------------------------
module degenerate_triangle_filter
#(
    parameter int VERTICES   = 4096,
    parameter int COORD_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_we,
    input  logic [dtf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtf_pkg::THR_W-1:0]           cfg_data,
    input  logic                                op,
    input  logic [dtf_pkg::SLOT_W-1:0]          vertex_slot,
    input  logic signed [dtf_pkg::POS_W-1:0]    pos_x,
    input  logic signed [dtf_pkg::POS_W-1:0]    pos_y,
    input  logic signed [dtf_pkg::POS_W-1:0]    pos_z,
    input  logic [dtf_pkg::IDX_W-1:0]           corner_a,
    input  logic [dtf_pkg::IDX_W-1:0]           corner_b,
    input  logic [dtf_pkg::IDX_W-1:0]           corner_c,
    output logic                                done,
    output logic                                kept,
    output logic [1:0]                          status,
    output logic [dtf_pkg::IDX_W-1:0]           out_a,
    output logic [dtf_pkg::IDX_W-1:0]           out_b,
    output logic [dtf_pkg::IDX_W-1:0]           out_c
);

    import dtf_pkg::*;

    localparam int AW    = $clog2(VERTICES > 1 ? VERTICES : 2);
    localparam int CB    = COORD_BITS;
    localparam int VW    = 3 * CB;
    localparam int D     = CB + 1;
    localparam int P     = 2 * D;
    localparam int MW    = 2 * D;
    localparam int L     = MW / 2;
    localparam int H     = MW - L;
    localparam int SQ_W  = 2 * MW;
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

    // configuration
    logic [COUNT_W-1:0] vertex_count_reg;
    logic [THR_W-1:0]   area_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg   <= '0;
            area_threshold_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERTEX_COUNT:   vertex_count_reg   <= cfg_data[COUNT_W-1:0];
                REG_AREA_THRESHOLD: area_threshold_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // entry: store write and reads
    logic [LIM_W-1:0]     limit;
    logic [IDX_W-1:0]     slot_ext;
    logic                 slot_ok;
    logic                 ram_we;
    logic [POS_EXT_W-1:0] px_ext;
    logic [POS_EXT_W-1:0] py_ext;
    logic [POS_EXT_W-1:0] pz_ext;
    logic [VW-1:0]        ram_wdata;
    logic [VW-1:0]        q_a;
    logic [VW-1:0]        q_b;
    logic [VW-1:0]        q_c;
    logic                 tri_in;
    tri_tag_t             tag_in;

    assign busy      = 1'b0;
    assign limit     = (LIM_W'(vertex_count_reg) < LIM_W'(VERTICES))
                     ? LIM_W'(vertex_count_reg) : LIM_W'(VERTICES);
    assign slot_ext  = IDX_W'(vertex_slot);
    assign slot_ok   = {1'b0, slot_ext} < LIM_W'(VERTICES);
    assign ram_we    = start && (op_t'(op) == OP_LOAD) && slot_ok;
    assign px_ext    = {{(POS_EXT_W-POS_W){1'b0}}, pos_x};
    assign py_ext    = {{(POS_EXT_W-POS_W){1'b0}}, pos_y};
    assign pz_ext    = {{(POS_EXT_W-POS_W){1'b0}}, pos_z};
    assign ram_wdata = {px_ext[CB-1:0], py_ext[CB-1:0], pz_ext[CB-1:0]};
    assign tri_in    = start && (op_t'(op) == OP_TRIANGLE);

    always_comb
    begin
        tag_in.a   = corner_a;
        tag_in.b   = corner_b;
        tag_in.c   = corner_c;
        tag_in.bad = ({1'b0, corner_a} >= limit) || ({1'b0, corner_b} >= limit)
                  || ({1'b0, corner_c} >= limit);
    end

    dtf_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_ram_a
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (corner_a[AW-1:0]),
        .rdata (q_a)
    );

    dtf_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_ram_b
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (corner_b[AW-1:0]),
        .rdata (q_b)
    );

    dtf_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_ram_c
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (corner_c[AW-1:0]),
        .rdata (q_c)
    );

    // valid and tag pipe
    logic [6:1] valid_reg;
    tri_tag_t   tag_reg [6:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[5:1], tri_in};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[1] <= tag_in;
        for (int i = 2; i <= 6; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
    end

    // stage 2: edge vectors
    logic signed [CB-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic signed [D-1:0]  e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;

    assign {ax, ay, az} = q_a;
    assign {bx, by, bz} = q_b;
    assign {cx, cy, cz} = q_c;

    always_ff @(posedge clk)
    begin
        e1x_reg <= D'(bx) - D'(ax);
        e1y_reg <= D'(by) - D'(ay);
        e1z_reg <= D'(bz) - D'(az);
        e2x_reg <= D'(cx) - D'(ax);
        e2y_reg <= D'(cy) - D'(ay);
        e2z_reg <= D'(cz) - D'(az);
    end

    // stage 3: cross product terms
    logic signed [P-1:0] p_reg [6];

    always_ff @(posedge clk)
    begin
        p_reg[0] <= P'(e1y_reg) * P'(e2z_reg);
        p_reg[1] <= P'(e1z_reg) * P'(e2y_reg);
        p_reg[2] <= P'(e1z_reg) * P'(e2x_reg);
        p_reg[3] <= P'(e1x_reg) * P'(e2z_reg);
        p_reg[4] <= P'(e1x_reg) * P'(e2y_reg);
        p_reg[5] <= P'(e1y_reg) * P'(e2x_reg);
    end

    // stage 4: cross components as magnitudes
    logic signed [P:0]  cr [3];
    logic        [P:0]  cr_abs [3];
    logic [MW-1:0]      mag_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cr[k]     = (P+1)'(p_reg[2*k]) - (P+1)'(p_reg[2*k+1]);
            cr_abs[k] = cr[k][P] ? -cr[k] : cr[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_reg[k] <= cr_abs[k][MW-1:0];
        end
    end

    // stage 5: partial products of the squares
    logic [2*H-1:0] hh_reg [3];
    logic [H+L-1:0] hl_reg [3];
    logic [2*L-1:0] ll_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            hh_reg[k] <= (2*H)'(mag_reg[k][MW-1:L]) * (2*H)'(mag_reg[k][MW-1:L]);
            hl_reg[k] <= (H+L)'(mag_reg[k][MW-1:L]) * (H+L)'(mag_reg[k][L-1:0]);
            ll_reg[k] <= (2*L)'(mag_reg[k][L-1:0]) * (2*L)'(mag_reg[k][L-1:0]);
        end
    end

    // stage 6: squares
    logic [SQ_W-1:0] sq_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_reg[k] <= SQ_W'({hh_reg[k], ll_reg[k]}) + (SQ_W'(hl_reg[k]) << (L + 1));
        end
    end

    // output: sum, threshold, status
    logic [SUM_W-1:0] sum;
    logic             degenerate;
    status_t          status_next;
    logic             done_reg;
    status_t          status_reg;
    logic [IDX_W-1:0] out_a_reg;
    logic [IDX_W-1:0] out_b_reg;
    logic [IDX_W-1:0] out_c_reg;

    assign sum        = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    assign degenerate = CMP_W'(sum) <= CMP_W'(area_threshold_reg);

    always_comb
    begin
        if (tag_reg[6].bad)
        begin
            status_next = STATUS_BAD_INDEX;
        end
        else if (degenerate)
        begin
            status_next = STATUS_DEGENERATE;
        end
        else
        begin
            status_next = STATUS_KEPT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        out_a_reg  <= tag_reg[6].a;
        out_b_reg  <= tag_reg[6].b;
        out_c_reg  <= tag_reg[6].c;
    end

    assign done   = done_reg;
    assign kept   = (status_reg == STATUS_KEPT);
    assign status = status_reg;
    assign out_a  = out_a_reg;
    assign out_b  = out_b_reg;
    assign out_c  = out_c_reg;

endmodule

### sv/dtf_ram.sv
// ----------------------------------------------------------------------------
// dtf_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dtf_ram
#(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
)
(
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### verif/tb_degenerate_triangle_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_degenerate_triangle_filter
// Self-checking bench for the degenerate triangle filter. Vertex loads and
// triangle words go in as random bursts under several register settings. A
// scoreboard keeps its own vertex store and predicts each verdict exactly.
// ----------------------------------------------------------------------------

typedef struct {
    bit               kept;
    dtf_pkg::status_t status;
    bit [15:0]        a;
    bit [15:0]        b;
    bit [15:0]        c;
} tri_verdict_t;

class triangle_scoreboard;
    bit signed [15:0] px [4096];
    bit signed [15:0] py [4096];
    bit signed [15:0] pz [4096];
    bit [12:0]        vertex_count;
    bit [62:0]        area_threshold;
    tri_verdict_t     verdicts [64];
    bit [5:0]         vq_head;
    bit [5:0]         vq_tail;
    int               vq_count;
    int               mismatches;
    int               loads;
    int               triangles;
    int               n_kept;
    int               n_bad;
    int               n_degenerate;

    function void set_reg(logic [dtf_pkg::CFG_IDX_W-1:0] idx, bit [62:0] value);
        if (idx == dtf_pkg::REG_VERTEX_COUNT)
            vertex_count = value[12:0];
        else
            area_threshold = value;
    endfunction

    function int count_limit();
        return (vertex_count > 13'd4096) ? 4096 : int'(vertex_count);
    endfunction

    function int pending();
        return vq_count;
    endfunction

    function bit [127:0] square(longint v);
        bit [127:0] m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function bit [127:0] cross_square(bit [15:0] a, bit [15:0] b, bit [15:0] c);
        longint e1x, e1y, e1z, e2x, e2y, e2z;
        longint cx, cy, cz;
        e1x = longint'(px[b]) - longint'(px[a]);
        e1y = longint'(py[b]) - longint'(py[a]);
        e1z = longint'(pz[b]) - longint'(pz[a]);
        e2x = longint'(px[c]) - longint'(px[a]);
        e2y = longint'(py[c]) - longint'(py[a]);
        e2z = longint'(pz[c]) - longint'(pz[a]);
        cx = e1y * e2z - e1z * e2y;
        cy = e1z * e2x - e1x * e2z;
        cz = e1x * e2y - e1y * e2x;
        return square(cx) + square(cy) + square(cz);
    endfunction

    function void note_word(logic op, bit [11:0] slot, bit [15:0] x, bit [15:0] y,
                            bit [15:0] z, bit [15:0] a, bit [15:0] b, bit [15:0] c);
        tri_verdict_t v;
        int           lim;
        if (op == dtf_pkg::OP_LOAD)
        begin
            px[slot] = x;
            py[slot] = y;
            pz[slot] = z;
            loads++;
            return;
        end
        triangles++;
        v.a = a;
        v.b = b;
        v.c = c;
        lim = count_limit();
        if (a >= lim || b >= lim || c >= lim)
        begin
            v.kept   = 1'b0;
            v.status = dtf_pkg::STATUS_BAD_INDEX;
            n_bad++;
        end
        else if (cross_square(a, b, c) <= {65'd0, area_threshold})
        begin
            v.kept   = 1'b0;
            v.status = dtf_pkg::STATUS_DEGENERATE;
            n_degenerate++;
        end
        else
        begin
            v.kept   = 1'b1;
            v.status = dtf_pkg::STATUS_KEPT;
            n_kept++;
        end
        verdicts[vq_tail] = v;
        vq_tail++;
        vq_count++;
    endfunction

    function void check_word(logic kept, logic [1:0] status, logic [15:0] a,
                             logic [15:0] b, logic [15:0] c);
        tri_verdict_t v;
        if (vq_count == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kept=%0b status=%0d a=%0d b=%0d c=%0d",
                         kept, status, a, b, c);
            return;
        end
        v = verdicts[vq_head];
        vq_head++;
        vq_count--;
        if (kept !== v.kept || status !== v.status || a !== v.a || b !== v.b
            || c !== v.c)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch: expected kept=%0b status=%s a=%0d b=%0d c=%0d",
                         v.kept, v.status.name(), v.a, v.b, v.c);
                $display("          got      kept=%0b status=%0d a=%0d b=%0d c=%0d",
                         kept, status, a, b, c);
            end
        end
    endfunction
endclass

module tb_degenerate_triangle_filter;
    import dtf_pkg::*;

    localparam int SLOTS        = 4096;
    localparam int DRAIN_CYCLES = 12;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    start       = 1'b0;
    logic                    cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [THR_W-1:0]        cfg_data    = '0;
    logic                    op          = 1'b0;
    logic [SLOT_W-1:0]       vertex_slot = '0;
    logic signed [POS_W-1:0] pos_x       = '0;
    logic signed [POS_W-1:0] pos_y       = '0;
    logic signed [POS_W-1:0] pos_z       = '0;
    logic [IDX_W-1:0]        corner_a    = '0;
    logic [IDX_W-1:0]        corner_b    = '0;
    logic [IDX_W-1:0]        corner_c    = '0;
    logic                    busy;
    logic                    done;
    logic                    kept;
    logic [1:0]              status;
    logic [IDX_W-1:0]        out_a;
    logic [IDX_W-1:0]        out_b;
    logic [IDX_W-1:0]        out_c;

    triangle_scoreboard sb = new;

    bit sending;
    bit no_idle;
    int burst_left;
    bit written [SLOTS];
    int written_slots [SLOTS];
    int n_written;

    degenerate_triangle_filter i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .vertex_slot (vertex_slot),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .corner_a    (corner_a),
        .corner_b    (corner_b),
        .corner_c    (corner_c),
        .done        (done),
        .kept        (kept),
        .status      (status),
        .out_a       (out_a),
        .out_b       (out_b),
        .out_c       (out_c)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_word(op, vertex_slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c);
        if (rst_n && done)
            sb.check_word(kept, status, out_a, out_b, out_c);
    end

    task automatic stop_sending();
        if (sending)
        begin
            start   <= 1'b0;
            sending  = 1'b0;
        end
    endtask

    task automatic send_word(input logic o, input bit [11:0] slot,
                             input bit [15:0] x, y, z, input bit [15:0] a, b, c);
        op          <= o;
        vertex_slot <= slot;
        pos_x       <= x;
        pos_y       <= y;
        pos_z       <= z;
        corner_a    <= a;
        corner_b    <= b;
        corner_c    <= c;
        start       <= 1'b1;
        sending      = 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (o == OP_LOAD && !written[slot])
        begin
            written[slot] = 1'b1;
            written_slots[n_written] = int'(slot);
            n_written++;
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(24, 1);
            if (!no_idle)
            begin
                stop_sending();
                repeat ($urandom_range(6, 1)) @(posedge clk);
            end
        end
    endtask

    // hold off until every verdict is back and the pipe is empty
    task automatic drain();
        stop_sending();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input bit [12:0] count, input bit [62:0] thr);
        cfg_index <= REG_VERTEX_COUNT;
        cfg_data  <= THR_W'(count);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_index <= REG_AREA_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(REG_VERTEX_COUNT, THR_W'(count));
        sb.set_reg(REG_AREA_THRESHOLD, thr);
    endtask

    task automatic load_word(input bit [11:0] slot, input bit [15:0] x, y, z);
        send_word(OP_LOAD, slot, x, y, z, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic triangle_word(input bit [15:0] a, b, c);
        send_word(OP_TRIANGLE, 12'hFFF, 16'h8000, 16'h7FFF, 16'hFFFF, a, b, c);
    endtask

    function automatic bit [15:0] rand_coord();
        bit signed [15:0] r;
        r = 16'($urandom);
        if ($urandom_range(2, 0) == 0)
            return r;
        return r >>> $urandom_range(15, 1);
    endfunction

    function automatic bit [62:0] rand_threshold();
        bit [62:0] t;
        t = 63'({$urandom, $urandom});
        return t >> $urandom_range(62, 0);
    endfunction

    // pick a loaded slot below the count, else an index out of range
    function automatic bit [15:0] pick_corner(int lim);
        int s;
        if (n_written != 0 && $urandom_range(9, 0) != 0)
        begin
            repeat (8)
            begin
                s = written_slots[$urandom_range(n_written - 1, 0)];
                if (s < lim)
                    return 16'(s);
            end
        end
        return 16'($urandom_range(65535, lim));
    endfunction

    task automatic random_phase(input int items);
        int        lim;
        int        n;
        int        sel;
        bit [11:0] slot;
        bit [15:0] a, b, c;
        lim = sb.count_limit();
        for (n = 0; n < items; n++)
        begin
            if ($urandom_range(99, 0) < 35)
            begin
                if (lim > 0 && $urandom_range(9, 0) < 7)
                    slot = 12'($urandom_range(lim - 1, 0));
                else
                    slot = 12'($urandom);
                send_word(OP_LOAD, slot, rand_coord(), rand_coord(), rand_coord(),
                          16'($urandom), 16'($urandom), 16'($urandom));
            end
            else
            begin
                a   = pick_corner(lim);
                b   = pick_corner(lim);
                c   = pick_corner(lim);
                sel = $urandom_range(9, 0);
                if (sel == 0)
                    b = a;
                else if (sel == 1)
                    c = a;
                else if (sel == 2)
                    c = b;
                send_word(OP_TRIANGLE, 12'($urandom), rand_coord(), rand_coord(),
                          rand_coord(), a, b, c);
            end
            if ($urandom_range(59, 0) == 0)
                drain();
        end
        drain();
    endtask

    initial
    begin
        int p;
        sending    = 1'b0;
        no_idle    = 1'b0;
        n_written  = 0;
        burst_left = $urandom_range(24, 1);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(13'd0, 63'd0);
        load_word(12'd0, 16'h8000, 16'h8000, 16'h8000);
        load_word(12'd1, 16'h7FFF, 16'h8000, 16'h0000);
        load_word(12'd2, 16'h0000, 16'h7FFF, 16'h7FFF);
        load_word(12'd4095, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        load_word(12'd10, 16'd0, 16'd0, 16'd0);
        load_word(12'd11, 16'd1, 16'd0, 16'd0);
        load_word(12'd12, 16'd0, 16'd1, 16'd0);
        load_word(12'd13, 16'd2, 16'd0, 16'd0);
        triangle_word(16'd0, 16'd1, 16'd2);
        triangle_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();

        configure(13'h1FFF, 63'd0);
        triangle_word(16'd0, 16'd1, 16'd2);
        triangle_word(16'd4095, 16'd0, 16'd1);
        triangle_word(16'd10, 16'd11, 16'd12);
        triangle_word(16'd10, 16'd11, 16'd13);
        triangle_word(16'd2, 16'd2, 16'd2);
        triangle_word(16'd0, 16'd1, 16'd4096);
        triangle_word(16'hFFFF, 16'd0, 16'd1);
        drain();

        configure(13'd13, 63'd1);
        triangle_word(16'd10, 16'd11, 16'd12);
        triangle_word(16'd12, 16'd11, 16'd10);
        triangle_word(16'd0, 16'd1, 16'd12);
        triangle_word(16'd0, 16'd1, 16'd13);
        drain();

        configure(13'd4096, {63{1'b1}});
        triangle_word(16'd0, 16'd1, 16'd2);
        triangle_word(16'd4095, 16'd0, 16'd1);
        drain();

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: configure(13'($urandom_range(64, 3)), rand_threshold());
                1: configure(13'd4096, 63'd0);
                2: configure(13'h1FFF, {63{1'b1}});
                3: configure(13'd1, rand_threshold());
                4: configure(13'($urandom), rand_threshold());
                5: configure(13'd4096, rand_threshold());
                6: configure(13'($urandom_range(4096, 3)), rand_threshold());
                default: configure(13'd4095, rand_threshold());
            endcase
            no_idle = (p == 4);
            random_phase(125);
        end

        $display("Run covered %0d vertex loads and %0d triangles: %0d kept, %0d bad index, %0d degenerate.",
                 sb.loads, sb.triangles, sb.n_kept, sb.n_bad, sb.n_degenerate);
        $display("Vertex counts from 0 to 8191 and thresholds from 0 to full scale; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
sv/dtf_pkg.sv
sv/dtf_ram.sv
sv/degenerate_triangle_filter.sv
verif/tb_degenerate_triangle_filter.sv
